### hdl/acc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acc_pkg
// Shared widths, constants and controller/datapath command and status types
// for the amount compression codec.
// ----------------------------------------------------------------------------
package acc_pkg;

   localparam int VALUE_W   = 64;
   localparam int DIGIT_W   = 4;
   localparam int EXP_W     = 4;
   localparam int DIV_BITS  = 16;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // chunk divide: remainder on top of one chunk, times a scaled reciprocal
   localparam int DIVD_W      = DIGIT_W + DIV_BITS;
   localparam int RECIP_W     = 20;
   localparam int PROD_W      = DIVD_W + RECIP_W;
   localparam int RECIP_SHIFT = 23;

   localparam logic [DIGIT_W:0]   RADIX     = 5'd10;
   localparam logic [DIGIT_W:0]   NINE      = 5'd9;
   localparam logic [EXP_W-1:0]   MAX_EXP   = 4'd9;
   localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

   // ceil(2^23 / 10) and ceil(2^23 / 9), exact for every chunk dividend
   localparam logic [RECIP_W-1:0] RECIP_TEN  = 20'd838861;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 20'd932068;

   typedef enum logic [3:0] {
      OP_NONE        = 4'd0,
      OP_LOAD        = 4'd1,
      OP_DIV         = 4'd2,
      OP_DEC         = 4'd3,
      OP_INC         = 4'd4,
      OP_MUL9        = 4'd5,
      OP_MUL10       = 4'd6,
      OP_ADD_REM_DEC = 4'd7,
      OP_ADD_REM_INC = 4'd8,
      OP_ADD_EXP_INC = 4'd9
   } dp_op_type;

   typedef enum logic [2:0] {
      EXP_HOLD = 3'd0,
      EXP_CLR  = 3'd1,
      EXP_INC  = 3'd2,
      EXP_DEC  = 3'd3,
      EXP_REM  = 3'd4
   } exp_op_type;

   typedef struct packed {
      dp_op_type  op;
      exp_op_type exp_op;
      logic       div_first;
      logic       div_nine;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic rem_zero;
      logic rem_max;
      logic e_zero;
      logic e_max;
   } dp_stat_type;

endpackage
`default_nettype wire

### hdl/acc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acc_if
// Valid/ready channels of the codec: request beat and response beat.
// ----------------------------------------------------------------------------
interface acc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [acc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface acc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [acc_pkg::VALUE_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface
`default_nettype wire

### hdl/acc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acc_datapath
// Working register, divide by 10 or 9 one 16-bit chunk per cycle through a
// reciprocal multiply, shift-add multiply by 9 and 10, exponent counter and
// the result register.
// ----------------------------------------------------------------------------
module acc_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire acc_pkg::dp_cmd_type         cmd,
   input  wire logic [acc_pkg::VALUE_W-1:0] req_value,
   output acc_pkg::dp_stat_type             stat,
   output logic [acc_pkg::VALUE_W-1:0]      rsp_result
);

   logic [acc_pkg::VALUE_W-1:0] n_ff, n_in;
   logic [acc_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [acc_pkg::EXP_W-1:0]   e_ff, e_in;
   logic [acc_pkg::VALUE_W-1:0] result_ff, result_in;

   logic [acc_pkg::VALUE_W-1:0] div_q;
   logic [acc_pkg::DIGIT_W-1:0] div_r;

   // long division by chunks, top chunk first; quotient chunks shift in at the
   // bottom of n and the running remainder stays in rem
   always_comb begin
      logic [acc_pkg::DIGIT_W:0]    divisor;
      logic [acc_pkg::RECIP_W-1:0]  recip;
      logic [acc_pkg::DIGIT_W-1:0]  rem_prev;
      logic [acc_pkg::DIVD_W-1:0]   dividend;
      logic [acc_pkg::PROD_W-1:0]   prod;
      logic [acc_pkg::DIV_BITS-1:0] q;
      logic [acc_pkg::DIVD_W-1:0]   back;
      logic [acc_pkg::DIVD_W-1:0]   diff;
      divisor  = cmd.div_nine ? acc_pkg::NINE : acc_pkg::RADIX;
      recip    = cmd.div_nine ? acc_pkg::RECIP_NINE : acc_pkg::RECIP_TEN;
      rem_prev = cmd.div_first ? '0 : rem_ff;
      dividend = {rem_prev, n_ff[acc_pkg::VALUE_W-1 -: acc_pkg::DIV_BITS]};
      prod     = {{acc_pkg::RECIP_W{1'b0}}, dividend}
                 * {{acc_pkg::DIVD_W{1'b0}}, recip};
      q        = prod[acc_pkg::RECIP_SHIFT +: acc_pkg::DIV_BITS];
      back     = {{acc_pkg::DIGIT_W{1'b0}}, q}
                 * {{(acc_pkg::DIVD_W-acc_pkg::DIGIT_W-1){1'b0}}, divisor};
      diff     = dividend - back;
      div_q    = {n_ff[acc_pkg::VALUE_W-acc_pkg::DIV_BITS-1:0], q};
      div_r    = diff[acc_pkg::DIGIT_W-1:0];
   end

   always_comb begin
      n_in = n_ff;
      case (cmd.op)
         acc_pkg::OP_LOAD:        n_in = req_value;
         acc_pkg::OP_DIV:         n_in = div_q;
         acc_pkg::OP_DEC:         n_in = n_ff - 64'd1;
         acc_pkg::OP_INC:         n_in = n_ff + 64'd1;
         acc_pkg::OP_MUL9:        n_in = {n_ff[acc_pkg::VALUE_W-4:0], 3'b000} + n_ff;
         acc_pkg::OP_MUL10:       n_in = {n_ff[acc_pkg::VALUE_W-4:0], 3'b000}
                                        + {n_ff[acc_pkg::VALUE_W-2:0], 1'b0};
         acc_pkg::OP_ADD_REM_DEC: n_in = n_ff + {60'd0, rem_ff} - 64'd1;
         acc_pkg::OP_ADD_REM_INC: n_in = n_ff + {60'd0, rem_ff} + 64'd1;
         acc_pkg::OP_ADD_EXP_INC: n_in = n_ff + {60'd0, e_ff} + 64'd1;
         default:                 n_in = n_ff;
      endcase
   end

   assign rem_in = (cmd.op == acc_pkg::OP_DIV) ? div_r : rem_ff;

   always_comb begin
      e_in = e_ff;
      case (cmd.exp_op)
         acc_pkg::EXP_CLR: e_in = '0;
         acc_pkg::EXP_INC: e_in = e_ff + 4'd1;
         acc_pkg::EXP_DEC: e_in = e_ff - 4'd1;
         acc_pkg::EXP_REM: e_in = rem_ff;
         default:          e_in = e_ff;
      endcase
   end

   assign result_in = cmd.emit ? n_ff : result_ff;

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      result_ff <= result_in;
      if (reset) begin
         rem_ff <= '0;
         e_ff   <= '0;
      end else begin
         rem_ff <= rem_in;
         e_ff   <= e_in;
      end
   end

   assign stat.n_zero   = (n_ff == '0);
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.rem_max  = (rem_ff == acc_pkg::MAX_DIGIT);
   assign stat.e_zero   = (e_ff == '0);
   assign stat.e_max    = (e_ff == acc_pkg::MAX_EXP);

   assign rsp_result = result_ff;

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= acc_pkg::MAX_DIGIT)
      else $error("remainder out of digit range");

   a_exp_bounded: assert property (@(posedge clock) disable iff (reset)
      e_ff <= acc_pkg::MAX_EXP)
      else $error("exponent above nine");

   a_load_clears_exp: assert property (@(posedge clock) disable iff (reset)
      cmd.op == acc_pkg::OP_LOAD && cmd.exp_op == acc_pkg::EXP_CLR |=> e_ff == '0)
      else $error("exponent not cleared on load");

endmodule
`default_nettype wire

### hdl/acc_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acc_controller
// Sequencer for compress and decompress: steps the datapath through the
// divide, multiply and add phases and owns the response valid.
// ----------------------------------------------------------------------------
module acc_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire acc_pkg::dp_stat_type stat,
   output acc_pkg::dp_cmd_type       cmd
);

   typedef enum logic [18:0] {
      ST_IDLE    = 19'h00001,
      ST_CHECK   = 19'h00002,
      ST_C_DIV   = 19'h00004,
      ST_C_TEST  = 19'h00008,
      ST_C_LOOP  = 19'h00010,
      ST_C_MUL9  = 19'h00020,
      ST_C_ADDR  = 19'h00040,
      ST_C_DEC9  = 19'h00080,
      ST_C_MUL10 = 19'h00100,
      ST_C_ADDE  = 19'h00200,
      ST_X_DEC   = 19'h00400,
      ST_X_DIV10 = 19'h00800,
      ST_X_TEST  = 19'h01000,
      ST_X_INC   = 19'h02000,
      ST_X_DIV9  = 19'h04000,
      ST_X_MUL10 = 19'h08000,
      ST_X_ADDD  = 19'h10000,
      ST_X_SCALE = 19'h20000,
      ST_FIN     = 19'h40000
   } state_type;

   state_type                 state_ff, state_in;
   logic [acc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      kind_ff, kind_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accept;
   logic                      div_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign div_last  = (cnt_ff == acc_pkg::CNT_W'(acc_pkg::DIV_STEPS - 1));
   assign kind_in   = accept ? req_kind : kind_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      cmd.op        = acc_pkg::OP_NONE;
      cmd.exp_op    = acc_pkg::EXP_HOLD;
      cmd.div_first = (cnt_ff == '0);
      cmd.div_nine  = 1'b0;
      cmd.emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op     = acc_pkg::OP_LOAD;
               cmd.exp_op = acc_pkg::EXP_CLR;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.n_zero) begin
               state_in = ST_FIN;
            end else if (kind_ff) begin
               state_in = ST_X_DEC;
            end else begin
               state_in = ST_C_DIV;
            end
         end
         ST_C_DIV: begin
            cmd.op = acc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_C_TEST;
            end
         end
         ST_C_TEST: begin
            // zero digit: keep the quotient and count one more decimal zero
            if (stat.rem_zero) begin
               cmd.exp_op = acc_pkg::EXP_INC;
               state_in   = ST_C_LOOP;
            end else begin
               state_in = ST_C_MUL9;
            end
         end
         ST_C_LOOP: begin
            state_in = stat.e_max ? ST_C_DEC9 : ST_C_DIV;
         end
         ST_C_MUL9: begin
            cmd.op   = acc_pkg::OP_MUL9;
            state_in = ST_C_ADDR;
         end
         ST_C_ADDR: begin
            cmd.op   = acc_pkg::OP_ADD_REM_DEC;
            state_in = ST_C_MUL10;
         end
         ST_C_DEC9: begin
            cmd.op   = acc_pkg::OP_DEC;
            state_in = ST_C_MUL10;
         end
         ST_C_MUL10: begin
            cmd.op   = acc_pkg::OP_MUL10;
            state_in = ST_C_ADDE;
         end
         ST_C_ADDE: begin
            cmd.op   = acc_pkg::OP_ADD_EXP_INC;
            state_in = ST_FIN;
         end
         ST_X_DEC: begin
            cmd.op   = acc_pkg::OP_DEC;
            state_in = ST_X_DIV10;
         end
         ST_X_DIV10: begin
            cmd.op = acc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_X_TEST;
            end
         end
         ST_X_TEST: begin
            cmd.exp_op = acc_pkg::EXP_REM;
            state_in   = stat.rem_max ? ST_X_INC : ST_X_DIV9;
         end
         ST_X_INC: begin
            cmd.op   = acc_pkg::OP_INC;
            state_in = ST_X_SCALE;
         end
         ST_X_DIV9: begin
            cmd.op       = acc_pkg::OP_DIV;
            cmd.div_nine = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_X_MUL10;
            end
         end
         ST_X_MUL10: begin
            cmd.op   = acc_pkg::OP_MUL10;
            state_in = ST_X_ADDD;
         end
         ST_X_ADDD: begin
            cmd.op   = acc_pkg::OP_ADD_REM_INC;
            state_in = ST_X_SCALE;
         end
         ST_X_SCALE: begin
            if (stat.e_zero) begin
               state_in = ST_FIN;
            end else begin
               cmd.op     = acc_pkg::OP_MUL10;
               cmd.exp_op = acc_pkg::EXP_DEC;
            end
         end
         ST_FIN: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted beat did not start work");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside finish");

   a_div_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_C_TEST || state_ff == ST_X_TEST || state_ff == ST_X_MUL10
      |-> cnt_ff == '0)
      else $error("divider count not back at zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("pending response dropped");

endmodule
`default_nettype wire

### hdl/amount_compress_codec_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amount_compress_codec_unit
// Compact coding of 64-bit amounts: compress (kind 0) or decompress (kind 1).
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one beat per item: kind and value. It is taken only while
//   the unit is idle, so items are worked one at a time.
//   rsp_if returns exactly one beat per item: result, modulo 2^64.
// Work per item grows with each stripped decimal zero on compress and
// with e = (code - 1) mod 10 on decompress; a zero value skips both.
// Each divide by ten or nine works one 16-bit chunk per cycle through a
// reciprocal multiply.
// Reset returns the sequencer to idle and empties the response register.
// The response sits in an output register: a new request is taken while it
// still waits, and a stalled receiver only holds the next item at its finish
// step until the register is taken.
// ----------------------------------------------------------------------------
module amount_compress_codec_unit (
   input  wire logic clock,
   input  wire logic reset,
   acc_req_if.sink   req_if,
   acc_rsp_if.source rsp_if
);

   acc_pkg::dp_cmd_type  cmd;
   acc_pkg::dp_stat_type stat;

   acc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   acc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_if.value),
      .stat       (stat),
      .rsp_result (rsp_if.result)
   );

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the amount compression codec. Directed beats cover
// zero, the widest values, every stripped-zero count and every code exponent.
// Random beats follow, about half of them amounts with trailing zeros and codes that
// come from real amounts. Each result is checked against a local model, in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int VALUE_W = acc_pkg::VALUE_W;

   localparam logic KIND_COMPRESS = 1'b0;
   localparam logic KIND_EXPAND   = 1'b1;

   localparam logic [VALUE_W-1:0] TEN     = 64'd10;
   localparam logic [VALUE_W-1:0] NINE_W  = 64'd9;
   localparam logic [VALUE_W-1:0] ONE     = 64'd1;
   localparam int unsigned        TOP_EXP = 9;

   localparam int unsigned MAX_WAIT     = 14;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned CHUNK        = 50;

   typedef struct {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] result;
   } codec_beat_type;

   logic clock = 1'b0;
   logic reset;

   acc_req_if req_bus ();
   acc_rsp_if rsp_bus ();

   amount_compress_codec_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   codec_beat_type pending_results[$];
   int unsigned    mismatch_count = 0;
   bit             quiet_req = 1'b0;
   bit             quiet_rsp = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // local model
   // ---------------------------------------------------------------------
   function automatic logic [VALUE_W-1:0] pow10(input int unsigned k);
      logic [VALUE_W-1:0] p;
      p = ONE;
      repeat (k) p = p * TEN;
      return p;
   endfunction

   function automatic logic [VALUE_W-1:0] compress_amount(input logic [VALUE_W-1:0] amount);
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] digit;
      int unsigned        e;
      n = amount;
      e = 0;
      if (n == '0)
         return '0;
      while ((n % TEN) == '0 && e < TOP_EXP) begin
         n = n / TEN;
         e++;
      end
      if (e < TOP_EXP) begin
         digit = n % TEN;
         n = n / TEN;
         return ONE + (n * NINE_W + digit - ONE) * TEN + 64'(e);
      end
      return ONE + (n - ONE) * TEN + NINE_W;
   endfunction

   function automatic logic [VALUE_W-1:0] expand_code(input logic [VALUE_W-1:0] code);
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] n;
      int unsigned        e;
      if (code == '0)
         return '0;
      x = code - ONE;
      e = int'(x % TEN);
      x = x / TEN;
      if (e < TOP_EXP)
         n = (x / NINE_W) * TEN + (x % NINE_W) + ONE;
      else
         n = x + ONE;
      repeat (e) n = n * TEN;
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // random values
   // ---------------------------------------------------------------------
   function automatic logic [VALUE_W-1:0] random_amount();
      logic [VALUE_W-1:0] mant;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 100000));
         2: begin
            mant = 64'($urandom_range(1, 1000000));
            return mant * pow10($urandom_range(0, 13));
         end
         default: begin
            // wide mantissa, product may wrap
            mant = {$urandom, $urandom} >> $urandom_range(20, 63);
            return mant * pow10($urandom_range(0, 19));
         end
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] random_code();
      case ($urandom_range(0, 3))
         0:       return {$urandom, $urandom};
         1:       return 64'($urandom_range(0, 5000));
         default: return compress_amount(random_amount());
      endcase
   endfunction

   function automatic void pick_quiet();
      quiet_req = ($urandom_range(0, 4) == 0);
      quiet_rsp = ($urandom_range(0, 4) == 0);
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [VALUE_W-1:0] value);
      int unsigned    gap;
      codec_beat_type beat;
      gap = quiet_req ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      beat.kind   = kind;
      beat.value  = value;
      beat.result = (kind == KIND_EXPAND) ? expand_code(value) : compress_amount(value);
      pending_results = {pending_results, beat};
   endtask

   // ---------------------------------------------------------------------
   // response side: stall counted from the moment a beat is offered
   // ---------------------------------------------------------------------
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = quiet_rsp ? 0 : $urandom_range(0, MAX_WAIT);
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            do @(posedge clock); while (!rsp_bus.valid);
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      codec_beat_type beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            flag_error($sformatf("result beat %h with nothing outstanding", rsp_bus.result));
         end else begin
            beat = pending_results.pop_front();
            if (rsp_bus.result !== beat.result)
               flag_error($sformatf("kind %0d value %h: expected %h, got %h",
                                    beat.kind, beat.value, beat.result, rsp_bus.result));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_zero();
      send_item(KIND_COMPRESS, '0);
      send_item(KIND_EXPAND, '0);
   endtask

   task automatic test_extremes();
      send_item(KIND_COMPRESS, '1);
      send_item(KIND_EXPAND, '1);
      send_item(KIND_COMPRESS, 64'd9);
      // exponent nine code, smallest and one that wraps
      send_item(KIND_EXPAND, 64'd10);
      send_item(KIND_EXPAND, 64'hFFFF_FFFF_FFFF_FFFA);
   endtask

   task automatic test_trailing_zeros();
      logic [VALUE_W-1:0] mant;
      for (int unsigned k = 0; k <= TOP_EXP; k++) begin
         mant = 64'($urandom_range(1, 99999));
         if (mant % TEN == '0)
            mant = mant + ONE;
         send_item(KIND_COMPRESS, mant * pow10(k));
      end
      // more zeros than the exponent can hold
      send_item(KIND_COMPRESS, pow10(19));
   endtask

   task automatic test_code_exponents();
      logic [VALUE_W-1:0] m;
      for (int unsigned e = 0; e < TOP_EXP; e++) begin
         m = {$urandom, $urandom} >> $urandom_range(4, 60);
         send_item(KIND_EXPAND, ONE + m * TEN + 64'(e));
      end
   endtask

   task automatic test_random_compress();
      for (int unsigned i = 0; i < 500; i++) begin
         if (i % CHUNK == 0)
            pick_quiet();
         send_item(KIND_COMPRESS, random_amount());
      end
   endtask

   task automatic test_random_expand();
      for (int unsigned i = 0; i < 500; i++) begin
         if (i % CHUNK == 0)
            pick_quiet();
         send_item(KIND_EXPAND, random_code());
      end
   endtask

   task automatic test_random_mixed();
      logic kind;
      for (int unsigned i = 0; i < 450; i++) begin
         if (i % CHUNK == 0)
            pick_quiet();
         kind = 1'($urandom_range(0, 1));
         send_item(kind, (kind == KIND_EXPAND) ? random_code() : random_amount());
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_COMPRESS;
      req_bus.value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero();
      test_extremes();
      test_trailing_zeros();
      test_code_exponents();
      test_random_compress();
      test_random_expand();
      test_random_mixed();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
